[hdl/bcr_tick_pkg.sv]
// Shared types and constants for the battery current regulator tick block.
package bcr_tick_pkg;

  localparam int DUTY_W   = 10;
  localparam int SUM_W    = 16;
  localparam int TOTAL_W  = 32;
  localparam int ACC_W    = 24;
  localparam int TICK_W   = 8;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 8;
  localparam int AVG_N_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] DUTY_MAX         = 10'd1023;
  localparam logic [TICK_W-1:0] TICKS_PER_SECOND = 8'd200;
  localparam logic [SEC_W-1:0]  SECONDS_PER_MIN  = 6'd60;

  localparam logic [1:0] MODE_IDLE         = 2'd0;
  localparam logic [1:0] MODE_DISCHARGE_CC = 2'd1;
  localparam logic [1:0] MODE_CHARGE_CC    = 2'd2;
  localparam logic [1:0] MODE_CHARGE_CV    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TARGET = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SUM_W-1:0] voltage_sum;
    logic [SUM_W-1:0] current_sum;
    logic             restart;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  charge_duty;
    logic [DUTY_W-1:0]  discharge_duty;
    logic [TOTAL_W-1:0] charge_total;
    logic               duty_error;
    logic [SUM_W-1:0]   slow_voltage;
    logic [SUM_W-1:0]   slow_current;
    logic               averages_updated;
    logic [SEC_W-1:0]   seconds;
    logic [MIN_W-1:0]   minutes;
  } out_t;

endpackage

[hdl/battery_current_regulator_tick.sv]
// Battery current regulator: one control step per 5 ms tick transaction.
//
// Usage:
//   in_*  : valid/ready channel carrying mode, ADC voltage and current sums
//           and a restart flag for one tick.
//   out_* : valid/ready channel carrying both PWM duties, the charge total,
//           the sticky duty error, 256-tick averages and the run clock.
//   cfg_* : write-only register port (zero offset, current target, voltage
//           target), written while no transaction is in flight.
// The output register captures a transaction's result at the edge that
// accepts it. Throughput is one transaction per cycle while the receiver
// takes each result; the control step is a single pass of add, compare
// and increment logic between the state registers and the output register.
// When the receiver stalls, the output register holds its result and
// in_ready drops until the result is taken; a new transaction is accepted
// in the same cycle the held result leaves.
// Synchronous active-low reset clears all regulator state, the
// configuration registers and the output valid.
module battery_current_regulator_tick
  import bcr_tick_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SUM_W-1:0]     cfg_wdata
);

  logic [SUM_W-1:0]   zero_off_r, cur_tgt_r, volt_tgt_r;
  logic [DUTY_W-1:0]  chg_duty_r, dis_duty_r;
  logic [TOTAL_W-1:0] total_r;
  logic               err_r, cv_phase_r;
  logic [TICK_W-1:0]  tick_r;
  logic [SEC_W-1:0]   sec_r;
  logic [MIN_W-1:0]   min_r;
  logic [AVG_N_W-1:0] avg_tick_r;
  logic [ACC_W-1:0]   vacc_r, cacc_r;
  logic [SUM_W-1:0]   vavg_r, cavg_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [DUTY_W-1:0]  chg_duty_nxt, dis_duty_nxt;
  logic [TOTAL_W-1:0] total_nxt;
  logic               err_nxt, cv_phase_nxt;
  logic [TICK_W-1:0]  tick_nxt;
  logic [SEC_W-1:0]   sec_nxt;
  logic [MIN_W-1:0]   min_nxt;
  logic [AVG_N_W-1:0] avg_tick_nxt;
  logic [ACC_W-1:0]   vacc_nxt, cacc_nxt, vsum_acc, csum_acc;
  logic [SUM_W-1:0]   vavg_nxt, cavg_nxt;
  logic               updated;

  logic               in_fire;
  logic [TOTAL_W-1:0] total_base;
  logic               err_base;
  logic [SEC_W-1:0]   sec_base;
  logic [MIN_W-1:0]   min_base;
  logic [SUM_W:0]     dis_diff, chg_diff;
  logic [SUM_W-1:0]   dis_mag;
  logic               chg_pos, dis_over, chg_over, cv_over;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    total_base = in_data.restart ? '0 : total_r;
    err_base   = in_data.restart ? 1'b0 : err_r;
    sec_base   = in_data.restart ? '0 : sec_r;
    min_base   = in_data.restart ? '0 : min_r;

    tick_nxt = tick_r + TICK_W'(1);
    sec_nxt  = sec_base;
    min_nxt  = min_base;
    if ({1'b0, tick_r} + 9'd1 >= {1'b0, TICKS_PER_SECOND}) begin
      tick_nxt = '0;
      if ({1'b0, sec_base} + 7'd1 >= {1'b0, SECONDS_PER_MIN}) begin
        sec_nxt = '0;
        min_nxt = min_base + MIN_W'(1);
      end else begin
        sec_nxt = sec_base + SEC_W'(1);
      end
    end

    cv_phase_nxt = !cv_phase_r;

    vsum_acc     = vacc_r + ACC_W'(in_data.voltage_sum);
    csum_acc     = cacc_r + ACC_W'(in_data.current_sum);
    avg_tick_nxt = avg_tick_r + AVG_N_W'(1);
    updated      = (avg_tick_nxt == '0);
    vacc_nxt     = updated ? '0 : vsum_acc;
    cacc_nxt     = updated ? '0 : csum_acc;
    vavg_nxt     = updated ? vsum_acc[ACC_W-1:ACC_W-SUM_W] : vavg_r;
    cavg_nxt     = updated ? csum_acc[ACC_W-1:ACC_W-SUM_W] : cavg_r;

    dis_diff = {1'b0, in_data.current_sum} - {1'b0, zero_off_r};
    dis_mag  = dis_diff[SUM_W] ? '0 : dis_diff[SUM_W-1:0];
    dis_over = dis_mag > cur_tgt_r;
    chg_diff = {1'b0, zero_off_r} - {1'b0, in_data.current_sum};
    chg_pos  = !chg_diff[SUM_W] && (chg_diff[SUM_W-1:0] != '0);
    chg_over = chg_pos && (chg_diff[SUM_W-1:0] > cur_tgt_r);
    cv_over  = (in_data.mode == MODE_CHARGE_CV) && cv_phase_nxt &&
               (in_data.voltage_sum > volt_tgt_r);

    chg_duty_nxt = chg_duty_r;
    dis_duty_nxt = dis_duty_r;
    total_nxt    = total_base;
    err_nxt      = err_base;

    case (in_data.mode)
      MODE_DISCHARGE_CC: begin
        total_nxt = total_base + TOTAL_W'(dis_mag);
        if (dis_over) begin
          if (dis_duty_r != '0) dis_duty_nxt = dis_duty_r - DUTY_W'(1);
        end else if (dis_duty_r >= DUTY_MAX) begin
          dis_duty_nxt = DUTY_MAX;
          err_nxt      = 1'b1;
        end else begin
          dis_duty_nxt = dis_duty_r + DUTY_W'(1);
        end
      end
      MODE_CHARGE_CC, MODE_CHARGE_CV: begin
        if (chg_pos) total_nxt = total_base + TOTAL_W'(chg_diff[SUM_W-1:0]);
        if (chg_over || cv_over) begin
          if (chg_duty_r != '0) chg_duty_nxt = chg_duty_r - DUTY_W'(1);
        end else if (chg_duty_r >= DUTY_MAX) begin
          chg_duty_nxt = DUTY_MAX;
          err_nxt      = 1'b1;
        end else begin
          chg_duty_nxt = chg_duty_r + DUTY_W'(1);
        end
      end
      default: begin
        chg_duty_nxt = '0;
        dis_duty_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_off_r <= '0;
      cur_tgt_r  <= '0;
      volt_tgt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ZERO_OFFSET:    zero_off_r <= cfg_wdata;
        REG_CURRENT_TARGET: cur_tgt_r  <= cfg_wdata;
        REG_VOLTAGE_TARGET: volt_tgt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_duty_r  <= '0;
      dis_duty_r  <= '0;
      total_r     <= '0;
      err_r       <= 1'b0;
      cv_phase_r  <= 1'b0;
      tick_r      <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      avg_tick_r  <= '0;
      vacc_r      <= '0;
      cacc_r      <= '0;
      vavg_r      <= '0;
      cavg_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        chg_duty_r  <= chg_duty_nxt;
        dis_duty_r  <= dis_duty_nxt;
        total_r     <= total_nxt;
        err_r       <= err_nxt;
        cv_phase_r  <= cv_phase_nxt;
        tick_r      <= tick_nxt;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        avg_tick_r  <= avg_tick_nxt;
        vacc_r      <= vacc_nxt;
        cacc_r      <= cacc_nxt;
        vavg_r      <= vavg_nxt;
        cavg_r      <= cavg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r.charge_duty      <= chg_duty_nxt;
      out_r.discharge_duty   <= dis_duty_nxt;
      out_r.charge_total     <= total_nxt;
      out_r.duty_error       <= err_nxt;
      out_r.slow_voltage     <= vavg_nxt;
      out_r.slow_current     <= cavg_nxt;
      out_r.averages_updated <= updated;
      out_r.seconds          <= sec_nxt;
      out_r.minutes          <= min_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r < SECONDS_PER_MIN)
    else $error("seconds counter out of range");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < TICKS_PER_SECOND)
    else $error("tick counter out of range");

  a_err_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_r) |-> (chg_duty_r == DUTY_MAX || dis_duty_r == DUTY_MAX))
    else $error("duty error set without a saturated duty");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.mode == MODE_IDLE |=> chg_duty_r == '0 && dis_duty_r == '0)
    else $error("idle mode left a duty nonzero");

  a_avg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_r.averages_updated == (avg_tick_r == '0))
    else $error("average update flag out of step with block counter");
`endif

endmodule
